/* design/tsu_pkg.sv */
// Shared types and helpers for the TOML string unescape block.
// Used by tsu_front, tsu_queue, tsu_back and the top level.
package tsu_pkg;

  localparam int MaxRes = 5;
  localparam int CntW   = 3;

  typedef enum logic [1:0] {
    KIND_CONTENT = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_ERROR   = 2'd2
  } res_kind_t;

  typedef struct packed {
    res_kind_t   kind;
    logic [7:0]  data;
    logic        consumed;
  } res_t;

  // all results caused by one accepted item
  typedef struct packed {
    res_t [MaxRes-1:0] r;
    logic [CntW-1:0]   cnt;
  } bundle_t;

  localparam logic [7:0] ChSq    = 8'h27;
  localparam logic [7:0] ChDq    = 8'h22;
  localparam logic [7:0] ChBsl   = 8'h5C;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;

  function automatic res_t mk_res(res_kind_t k, logic [7:0] d, logic c);
    res_t r;
    r.kind = k;
    r.data = d;
    r.consumed = c;
    return r;
  endfunction

  // {ok, value}
  function automatic logic [4:0] hex_val(logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b >= 8'h30 && b <= 8'h39) r = {1'b1, b[3:0]};
    else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b[3:0] + 4'd9)};
    else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b[3:0] + 4'd9)};
    return r;
  endfunction

endpackage

/* design/tsu_front.sv */
// Front end: takes raw bytes, tracks string state and builds the result
// bundle of each item. Depends on tsu_pkg.
module tsu_front
  import tsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] data_byte,
  input  logic       start_of_value,
  input  logic       input_ended,
  output bundle_t    bundle,
  output logic       has_res
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_OPEN1, PH_OPEN2, PH_MLSTART, PH_MLCR, PH_BODY
  } phase_t;

  typedef struct packed {
    logic [1:0]  skind;
    phase_t      phase;
    logic        esc;
    logic [1:0]  fold;
    logic [3:0]  hex_left;
    logic [31:0] cp;
    logic [2:0]  qrun;
  } st_t;

  st_t st_r, st_nxt;

  always_comb begin
    st_t              s;
    res_t [MaxRes-1:0] r;
    logic [CntW-1:0]  n;
    logic [7:0]       b, q;
    logic             multi, basic, do_body, stop, skip, blank, nl, valid;
    logic [4:0]       hv;
    logic [31:0]      cp;
    s = st_r;
    r = '0;
    n = '0;
    b = data_byte;
    do_body = 1'b0;
    stop = 1'b0;
    skip = 1'b0;
    blank = (b == ChSpace) || (b == ChTab);
    nl = (b == ChLf) || (b == ChCr);
    hv = hex_val(b);
    cp = '0;

    if (input_ended || start_of_value) begin
      q = (s.skind < 2'd2) ? ChSq : ChDq;
      unique case (s.phase)
        PH_IDLE: ;
        PH_OPEN2: begin
          r[n] = mk_res(KIND_DONE, 8'h00, 1'b0); n = n + 1'b1; s = '0;
        end
        PH_BODY: begin
          if (s.skind[0] && s.qrun >= 3'd3 && s.qrun <= 3'd5) begin
            if (s.qrun >= 3'd4) begin r[n] = mk_res(KIND_CONTENT, q, 1'b0); n = n + 1'b1; end
            if (s.qrun >= 3'd5) begin r[n] = mk_res(KIND_CONTENT, q, 1'b0); n = n + 1'b1; end
            r[n] = mk_res(KIND_DONE, 8'h00, 1'b0); n = n + 1'b1;
          end else begin
            r[n] = mk_res(KIND_ERROR, 8'h00, 1'b0); n = n + 1'b1;
          end
          s = '0;
        end
        default: begin
          r[n] = mk_res(KIND_ERROR, 8'h00, 1'b0); n = n + 1'b1; s = '0;
        end
      endcase
      if (!input_ended) begin
        s = '0;
        if (b == ChSq) s.phase = PH_OPEN1;
        else if (b == ChDq) begin s.skind = 2'd2; s.phase = PH_OPEN1; end
        else begin r[n] = mk_res(KIND_ERROR, 8'h00, 1'b0); n = n + 1'b1; end
      end
    end else begin
      q = (s.skind < 2'd2) ? ChSq : ChDq;
      unique case (s.phase)
        PH_IDLE: ;
        PH_OPEN1: begin
          if (b == q) s.phase = PH_OPEN2;
          else begin s.phase = PH_BODY; do_body = 1'b1; end
        end
        PH_OPEN2: begin
          if (b == q) begin s.skind[0] = 1'b1; s.phase = PH_MLSTART; end
          else begin r[n] = mk_res(KIND_DONE, 8'h00, 1'b0); n = n + 1'b1; s = '0; end
        end
        PH_MLSTART: begin
          s.phase = PH_BODY;
          if (b == ChCr) s.phase = PH_MLCR;
          else if (b != ChLf) do_body = 1'b1;
        end
        PH_MLCR: begin
          s.phase = PH_BODY;
          if (b != ChLf) begin
            r[n] = mk_res(KIND_CONTENT, ChCr, 1'b0); n = n + 1'b1;
            do_body = 1'b1;
          end
        end
        PH_BODY: do_body = 1'b1;
        default: s = '0;
      endcase
    end

    multi = s.skind[0];
    basic = s.skind[1];
    q = (s.skind < 2'd2) ? ChSq : ChDq;
    valid = (b == ChTab) || (b >= 8'h20 && b <= 8'h7E) || b[7] || (multi && nl);

    if (do_body) begin
      if (s.hex_left != 4'd0) begin
        if (!hv[4]) begin
          r[n] = mk_res(KIND_ERROR, 8'h00, 1'b0); n = n + 1'b1; s = '0;
        end else begin
          cp = {s.cp[27:0], hv[3:0]};
          s.cp = cp;
          s.hex_left = s.hex_left - 4'd1;
          if (s.hex_left == 4'd0) begin
            if (cp > 32'h10FFFF || (cp >= 32'hD800 && cp <= 32'hDFFF)) begin
              r[n] = mk_res(KIND_ERROR, 8'h00, 1'b0); n = n + 1'b1; s = '0;
            end else begin
              if (cp < 32'h80) begin
                r[n] = mk_res(KIND_CONTENT, cp[7:0], 1'b0); n = n + 1'b1;
              end else if (cp < 32'h800) begin
                r[n] = mk_res(KIND_CONTENT, {3'b110, cp[10:6]}, 1'b0); n = n + 1'b1;
                r[n] = mk_res(KIND_CONTENT, {2'b10, cp[5:0]}, 1'b0); n = n + 1'b1;
              end else if (cp < 32'h10000) begin
                r[n] = mk_res(KIND_CONTENT, {4'b1110, cp[15:12]}, 1'b0); n = n + 1'b1;
                r[n] = mk_res(KIND_CONTENT, {2'b10, cp[11:6]}, 1'b0); n = n + 1'b1;
                r[n] = mk_res(KIND_CONTENT, {2'b10, cp[5:0]}, 1'b0); n = n + 1'b1;
              end else begin
                r[n] = mk_res(KIND_CONTENT, {5'b11110, cp[20:18]}, 1'b0); n = n + 1'b1;
                r[n] = mk_res(KIND_CONTENT, {2'b10, cp[17:12]}, 1'b0); n = n + 1'b1;
                r[n] = mk_res(KIND_CONTENT, {2'b10, cp[11:6]}, 1'b0); n = n + 1'b1;
                r[n] = mk_res(KIND_CONTENT, {2'b10, cp[5:0]}, 1'b0); n = n + 1'b1;
              end
              s.cp = '0;
            end
          end
        end
      end else if (s.esc) begin
        s.esc = 1'b0;
        unique case (b)
          8'h62: begin r[n] = mk_res(KIND_CONTENT, 8'h08, 1'b0); n = n + 1'b1; end
          8'h74: begin r[n] = mk_res(KIND_CONTENT, 8'h09, 1'b0); n = n + 1'b1; end
          8'h6E: begin r[n] = mk_res(KIND_CONTENT, 8'h0A, 1'b0); n = n + 1'b1; end
          8'h66: begin r[n] = mk_res(KIND_CONTENT, 8'h0C, 1'b0); n = n + 1'b1; end
          8'h72: begin r[n] = mk_res(KIND_CONTENT, 8'h0D, 1'b0); n = n + 1'b1; end
          ChDq:  begin r[n] = mk_res(KIND_CONTENT, ChDq, 1'b0); n = n + 1'b1; end
          ChBsl: begin r[n] = mk_res(KIND_CONTENT, ChBsl, 1'b0); n = n + 1'b1; end
          8'h75: begin s.hex_left = 4'd4; s.cp = '0; end
          8'h55: begin s.hex_left = 4'd8; s.cp = '0; end
          default: begin
            if (multi && blank) s.fold = 2'd1;
            else if (multi && nl) s.fold = 2'd2;
            else begin r[n] = mk_res(KIND_ERROR, 8'h00, 1'b0); n = n + 1'b1; s = '0; end
          end
        endcase
      end else if (s.fold == 2'd1) begin
        if (nl) s.fold = 2'd2;
        else if (!blank) begin
          r[n] = mk_res(KIND_ERROR, 8'h00, 1'b0); n = n + 1'b1; s = '0;
        end
      end else begin
        if (s.fold == 2'd2) begin
          if (blank || nl) skip = 1'b1;
          else s.fold = 2'd0;
        end
        if (!skip) begin
          if (b == q) begin
            if (!multi) begin
              r[n] = mk_res(KIND_DONE, 8'h00, 1'b1); n = n + 1'b1; s = '0;
            end else begin
              s.qrun = s.qrun + 3'd1;
              if (s.qrun > 3'd5) begin
                r[n] = mk_res(KIND_ERROR, 8'h00, 1'b0); n = n + 1'b1; s = '0;
              end
            end
          end else begin
            if (s.qrun >= 3'd3) begin
              if (s.qrun >= 3'd4) begin r[n] = mk_res(KIND_CONTENT, q, 1'b0); n = n + 1'b1; end
              if (s.qrun >= 3'd5) begin r[n] = mk_res(KIND_CONTENT, q, 1'b0); n = n + 1'b1; end
              r[n] = mk_res(KIND_DONE, 8'h00, 1'b0); n = n + 1'b1;
              s = '0;
              stop = 1'b1;
            end else if (s.qrun != 3'd0) begin
              r[n] = mk_res(KIND_CONTENT, q, 1'b0); n = n + 1'b1;
              if (s.qrun == 3'd2) begin r[n] = mk_res(KIND_CONTENT, q, 1'b0); n = n + 1'b1; end
              s.qrun = 3'd0;
            end
            if (!stop) begin
              if (!valid) begin
                r[n] = mk_res(KIND_ERROR, 8'h00, 1'b0); n = n + 1'b1; s = '0;
              end else if (basic && b == ChBsl) s.esc = 1'b1;
              else begin r[n] = mk_res(KIND_CONTENT, b, 1'b0); n = n + 1'b1; end
            end
          end
        end
      end
    end

    st_nxt = s;
    bundle.r = r;
    bundle.cnt = n;
    has_res = (n != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (acc) begin
      st_r <= st_nxt;
    end
  end

endmodule

/* design/tsu_queue.sv */
// Short bundle queue between the front end and the output serializer.
// Depends on tsu_pkg.
module tsu_queue
  import tsu_pkg::*;
#(
  parameter int Depth = 4
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t wdata,
  output logic    full,
  input  logic    pop,
  output logic    nonempty,
  output bundle_t rdata
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  bundle_t           mem_r [Depth];
  logic [PtrW-1:0]   wp_r, rp_r;
  logic [PtrW:0]     cnt_r;

  assign full = (cnt_r == (PtrW+1)'(Depth));
  assign nonempty = (cnt_r != '0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PtrW'(Depth - 1)) ? '0 : wp_r + 1'b1;
      if (pop) rp_r <= (rp_r == PtrW'(Depth - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

endmodule

/* design/tsu_back.sv */
// Back end: holds one bundle and hands out its results one per cycle while out_ready is high.
// Depends on tsu_pkg.
module tsu_back
  import tsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_nonempty,
  input  bundle_t    q_data,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [7:0] out_byte,
  output logic       byte_consumed,
  output logic       last_of_run
);

  bundle_t          cur_r;
  logic [CntW-1:0]  idx_r;
  logic             busy_r;
  res_t             sel;
  logic             last;

  assign sel = cur_r.r[idx_r];
  assign last = (idx_r == cur_r.cnt - 1'b1);
  assign q_pop = q_nonempty && (!busy_r || (out_ready && last));

  assign out_valid = busy_r;
  assign kind = sel.kind;
  assign out_byte = sel.data;
  assign byte_consumed = sel.consumed;
  assign last_of_run = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r <= '0;
    end else if (q_pop) begin
      busy_r <= 1'b1;
      idx_r <= '0;
    end else if (busy_r && out_ready) begin
      if (last) busy_r <= 1'b0;
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_data;
  end

endmodule

/* design/toml_string_unescape_top.sv */
// TOML string value decoder: one raw byte in, decoded bytes and done/error out.
// Depends on tsu_pkg, tsu_front, tsu_queue, tsu_back.
//
// One input item is taken every cycle while the bundle queue has room. Each
// item makes zero to five results, queued as one bundle; the output side
// sends one result per cycle while out_ready is high, so an item that expands
// (a unicode escape to up to four UTF-8 bytes, a closing quote run) holds its
// bundle until all are sent. Input stalls only once QueueDepth bundles wait.
module toml_string_unescape_top
  import tsu_pkg::*;
#(
  parameter int QueueDepth = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_start_of_value,
  input  logic       in_input_ended,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_out_byte,
  output logic       out_byte_consumed,
  output logic       out_last_of_run
);

  bundle_t fr_bundle, q_data;
  logic    fr_has, q_full, q_pop, q_nonempty, acc;

  assign in_ready = !q_full;
  assign acc = in_valid && in_ready;

  tsu_front u_front (
    .clk, .rst_n, .acc,
    .data_byte(in_data_byte),
    .start_of_value(in_start_of_value),
    .input_ended(in_input_ended),
    .bundle(fr_bundle),
    .has_res(fr_has)
  );

  tsu_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst_n,
    .push(acc && fr_has),
    .wdata(fr_bundle),
    .full(q_full),
    .pop(q_pop),
    .nonempty(q_nonempty),
    .rdata(q_data)
  );

  tsu_back u_back (
    .clk, .rst_n,
    .q_nonempty, .q_data, .q_pop,
    .out_valid, .out_ready,
    .kind(out_kind),
    .out_byte(out_out_byte),
    .byte_consumed(out_byte_consumed),
    .last_of_run(out_last_of_run)
  );

endmodule

/* design/tsu_checker.sv */
// Port-level checks for the TOML string decoder, bound to the top level.
// Depends on tsu_pkg.
module tsu_checker
  import tsu_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_out_byte,
  input logic       out_byte_consumed,
  input logic       out_last_of_run
);

  // checks that done and error close their item; a done followed by an error in one bundle fails it
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_DONE || out_kind == KIND_ERROR) |-> out_last_of_run)
    else $error("done/error not last of run");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind != 2'd3)
    else $error("bad result kind");

  a_no_byte_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_CONTENT |-> out_out_byte == 8'h00)
    else $error("byte on done/error");

  a_consumed_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_consumed |-> out_kind == KIND_DONE)
    else $error("consumed flag outside done");

  // a waiting result holds still
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_out_byte)
      && $stable(out_byte_consumed) && $stable(out_last_of_run))
    else $error("result changed while waiting");

endmodule

bind toml_string_unescape_top tsu_checker u_tsu_checker (
  .clk, .rst_n, .out_valid, .out_ready, .out_kind, .out_out_byte,
  .out_byte_consumed, .out_last_of_run
);
